>>> hdl/meq_pkg.sv
// Shared types and constants for the mouse event queue controller.
`default_nettype none
package meq_pkg;
    localparam logic [2:0] CMD_MOVE      = 3'd0;
    localparam logic [2:0] CMD_PRESS     = 3'd1;
    localparam logic [2:0] CMD_RELEASE   = 3'd2;
    localparam logic [2:0] CMD_POP       = 3'd3;
    localparam logic [2:0] CMD_RDPRESS   = 3'd4;
    localparam logic [2:0] CMD_RDRELEASE = 3'd5;
    localparam logic [2:0] CMD_RDMOTION  = 3'd6;
    localparam logic [2:0] CMD_RDSTATUS  = 3'd7;

    localparam logic [2:0] REG_TEXT_MODE  = 3'd0;
    localparam logic [2:0] REG_DOUBLE_Y   = 3'd1;
    localparam logic [2:0] REG_SCALE_X    = 3'd2;
    localparam logic [2:0] REG_SCALE_Y    = 3'd3;
    localparam logic [2:0] REG_EVENT_MASK = 3'd4;
    localparam logic [2:0] REG_EVEN_X     = 3'd5;
    localparam logic [2:0] REG_START_Y    = 3'd6;

    localparam logic [4:0] EV_MOVE      = 5'd1;
    localparam logic [4:0] EV_L_PRESS   = 5'd2;
    localparam logic [4:0] EV_L_RELEASE = 5'd4;
    localparam logic [4:0] EV_R_PRESS   = 5'd8;
    localparam logic [4:0] EV_R_RELEASE = 5'd16;

    localparam int unsigned DIV_W = 20;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] host_x;
        logic [15:0] host_y;
        logic [1:0]  button;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         buttons_now;
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic [15:0]        click_count;
        logic signed [15:0] motion_x;
        logic signed [15:0] motion_y;
        logic [4:0]         event_kind;
        logic [1:0]         event_buttons;
        logic               deliver;
        logic               pending;
    } t_out_item;

    typedef struct packed {
        logic [4:0] kind;
        logic [1:0] buttons;
    } t_event;

    // Queue control from the core to the cell row.
    typedef struct packed {
        logic   push;
        logic   pop;
        t_event din;
    } t_queue_ctl;
endpackage
`default_nettype wire

>>> hdl/meq_div_cell.sv
// One restoring-division cell: one quotient bit per cycle while i_step is high.
`default_nettype none
module meq_div_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_load,
    input  wire logic                       i_step,
    input  wire logic [meq_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [15:0]                i_divisor,
    output logic      [meq_pkg::DIV_W-1:0]  o_quot
);
    logic [meq_pkg::DIV_W-1:0] r_quot;
    logic [16:0]               r_rem;
    logic [15:0]               r_div;
    logic [17:0]               w_trial;
    logic [17:0]               w_sub;

    // Shift in the next dividend bit and try the subtraction.
    always_comb begin
        w_trial = {r_rem, r_quot[meq_pkg::DIV_W-1]};
        w_sub   = w_trial - {2'b00, r_div};
    end

    // Load operands, then advance one bit each step.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= (i_divisor == 16'd0) ? 16'd1 : i_divisor;
        end else if (i_step) begin
            if (!w_sub[17]) begin
                r_rem  <= w_sub[16:0];
                r_quot <= {r_quot[meq_pkg::DIV_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_trial[16:0];
                r_quot <= {r_quot[meq_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_quot;
endmodule
`default_nettype wire

>>> hdl/meq_queue_cell.sv
// One event queue cell: holds one entry and shifts it toward the tail on push.
`default_nettype none
module meq_queue_cell (
    input  wire logic                i_clk,
    input  wire meq_pkg::t_queue_ctl i_ctl,
    input  wire meq_pkg::t_event     i_prev,
    output meq_pkg::t_event          o_entry
);
    meq_pkg::t_event r_entry;

    // Take the neighbor's entry on push; pop only moves the fill count.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;
endmodule
`default_nettype wire

>>> hdl/mouse_event_queue_controller_core.sv
// Top level: command decode, scaling dividers, counters and event queue cell row.
// Sequence: a move first runs the DIV_W = 20 bit-serial dividers, then executes;
//   every other command goes straight to execute. The result is registered at execute.
// Flow: one item at a time; the next item is accepted the cycle after its execute
//   step; a held result stalls execute.
// Reset: synchronous active-low; clears control, counters and configuration to
//   defaults, sets the y position to 199; queue entries are not cleared.
`default_nettype none
module mouse_event_queue_controller_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire meq_pkg::t_in_item  i_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output meq_pkg::t_out_item      o_data,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(meq_pkg::DIV_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    // Configuration registers.
    logic        r_text_mode, r_double_y, r_even_x;
    logic [15:0] r_scale_x, r_scale_y, r_start_y;
    logic [4:0]  r_event_mask;

    // State.
    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_cnt;
    meq_pkg::t_in_item r_item;
    logic [1:0]  r_buttons;
    logic [15:0] r_cur_x, r_cur_y, r_mick_x, r_mick_y;
    logic [15:0] r_press_cnt [2];
    logic [15:0] r_rel_cnt   [2];
    logic [31:0] r_press_pos [2];
    logic [31:0] r_rel_pos   [2];
    logic [FILL_W-1:0] r_fill;
    logic        r_ovalid;
    meq_pkg::t_out_item r_out;

    logic        w_accept;
    logic        w_out_free;
    logic        w_exec;
    logic        w_load, w_step;
    logic [meq_pkg::DIV_W-1:0] w_dx_in, w_dy_in, w_dy2_in;
    logic [meq_pkg::DIV_W-1:0] w_qx, w_qy, w_qy2;
    meq_pkg::t_queue_ctl w_qctl;
    meq_pkg::t_event     w_cells [QUEUE_DEPTH];
    meq_pkg::t_event     w_pop_entry;

    assign w_accept   = i_valid && !o_stall;
    assign o_stall    = (r_state != ST_IDLE);
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_exec     = (r_state == ST_EXEC) && w_out_free;
    assign w_load     = w_accept && (i_data.cmd == meq_pkg::CMD_MOVE);
    assign w_step     = (r_state == ST_DIV);

    // Pre-scale host coordinates for text mode.
    always_comb begin
        if (r_text_mode) begin
            w_dx_in  = {1'b0, i_data.host_x, 3'b000};
            w_dy_in  = {1'b0, i_data.host_y, 3'b000};
            w_dy2_in = {i_data.host_y, 4'b0000};
        end else begin
            w_dx_in  = {4'b0000, i_data.host_x};
            w_dy_in  = {4'b0000, i_data.host_y};
            w_dy2_in = {4'b0000, i_data.host_y};
        end
    end

    meq_div_cell u_div_x (.i_clk, .i_load(w_load), .i_step(w_step),
        .i_dividend(w_dx_in), .i_divisor(r_scale_x), .o_quot(w_qx));
    meq_div_cell u_div_y (.i_clk, .i_load(w_load), .i_step(w_step),
        .i_dividend(w_dy_in), .i_divisor(r_scale_y), .o_quot(w_qy));
    meq_div_cell u_div_y2 (.i_clk, .i_load(w_load), .i_step(w_step),
        .i_dividend(w_dy2_in), .i_divisor(r_scale_y), .o_quot(w_qy2));

    // Event queue: cell 0 is the newest entry; the oldest sits at fill-1.
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                meq_queue_cell u_cell (.i_clk, .i_ctl(w_qctl), .i_prev(w_qctl.din),
                    .o_entry(w_cells[g]));
            end else begin : g_body
                meq_queue_cell u_cell (.i_clk, .i_ctl(w_qctl), .i_prev(w_cells[g-1]),
                    .o_entry(w_cells[g]));
            end
        end
    endgenerate

    // Execute stage: compute the next state, queue control and result.
    logic [15:0] n_cur_x, n_cur_y, n_mick_x, n_mick_y, w_nx, w_ny, w_rep_x;
    logic [1:0]  n_buttons;
    logic [FILL_W-1:0] n_fill;
    logic        w_b;
    logic        w_btn_ok;
    logic        w_want;
    meq_pkg::t_out_item n_out;
    logic [FILL_W-1:0] w_fill_m1;

    assign w_fill_m1   = r_fill - 1'b1;
    assign w_pop_entry = w_cells[w_fill_m1[IDX_W-1:0]];

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_mick_x = r_mick_x;
        n_mick_y = r_mick_y;
        n_buttons = r_buttons;
        n_fill   = r_fill;
        w_qctl   = '0;
        w_want   = 1'b0;
        n_out    = '0;
        w_nx     = w_qx[15:0];
        w_ny     = w_qy[15:0];
        w_btn_ok = !r_item.button[1];
        w_b      = r_item.button[1] | r_item.button[0];
        w_rep_x  = r_even_x ? (r_cur_x & 16'hfffe) : r_cur_x;
        case (r_item.cmd)
            meq_pkg::CMD_MOVE: begin
                n_mick_x = r_mick_x + w_nx - r_cur_x;
                if (r_text_mode) begin
                    n_mick_y = r_mick_y + {w_ny[14:0] - r_cur_y[14:0], 1'b0};
                    n_cur_y  = r_double_y ? w_qy2[15:0] : w_ny;
                end else begin
                    n_mick_y = r_mick_y + w_ny - r_cur_y;
                    n_cur_y  = w_ny;
                end
                n_cur_x = w_nx;
                if ((n_mick_x != 16'd0 || n_mick_y != 16'd0) && r_fill == '0) begin
                    w_qctl.din.kind = meq_pkg::EV_MOVE;
                    w_want = 1'b1;
                end
                w_qctl.din.buttons = r_buttons;
            end
            meq_pkg::CMD_PRESS, meq_pkg::CMD_RELEASE: begin
                if (w_btn_ok) begin
                    if (r_item.cmd == meq_pkg::CMD_PRESS) begin
                        n_buttons = r_buttons | (r_item.button[0] ? 2'b10 : 2'b01);
                        w_qctl.din.kind = r_item.button[0] ? meq_pkg::EV_R_PRESS
                                                           : meq_pkg::EV_L_PRESS;
                    end else begin
                        n_buttons = r_buttons & (r_item.button[0] ? 2'b01 : 2'b10);
                        w_qctl.din.kind = r_item.button[0] ? meq_pkg::EV_R_RELEASE
                                                           : meq_pkg::EV_L_RELEASE;
                    end
                    w_qctl.din.buttons = n_buttons;
                    w_want = 1'b1;
                end
            end
            meq_pkg::CMD_POP: begin
                if (r_fill != '0) begin
                    n_fill = w_fill_m1;
                    n_out.event_kind    = w_pop_entry.kind;
                    n_out.event_buttons = w_pop_entry.buttons;
                    n_out.deliver       = |(r_event_mask & w_pop_entry.kind);
                end
                n_out.motion_x = r_mick_x;
                n_out.motion_y = r_mick_y;
            end
            meq_pkg::CMD_RDPRESS: begin
                n_out.pos_x       = r_press_pos[w_b][15:0];
                n_out.pos_y       = r_press_pos[w_b][31:16];
                n_out.click_count = r_press_cnt[w_b];
            end
            meq_pkg::CMD_RDRELEASE: begin
                n_out.pos_x       = r_rel_pos[w_b][15:0];
                n_out.pos_y       = r_rel_pos[w_b][31:16];
                n_out.click_count = r_rel_cnt[w_b];
            end
            meq_pkg::CMD_RDMOTION: begin
                n_out.motion_x = r_mick_x;
                n_out.motion_y = r_mick_y;
                n_mick_x = '0;
                n_mick_y = '0;
            end
            default: begin
            end
        endcase
        // Shift the queue only in the cycle the item commits.
        if (w_want && r_fill < FILL_W'(QUEUE_DEPTH)) begin
            w_qctl.push = w_exec;
            n_fill = r_fill + 1'b1;
        end
        w_qctl.pop = w_exec && (r_item.cmd == meq_pkg::CMD_POP) && (r_fill != '0);
        n_out.buttons_now = n_buttons;
        if (r_item.cmd != meq_pkg::CMD_RDPRESS && r_item.cmd != meq_pkg::CMD_RDRELEASE) begin
            n_out.pos_x = r_even_x ? (n_cur_x & 16'hfffe) : n_cur_x;
            n_out.pos_y = n_cur_y;
        end
        if (r_item.cmd == meq_pkg::CMD_RDMOTION) begin
            n_out.buttons_now = '0;
            n_out.pos_x = '0;
            n_out.pos_y = '0;
        end
        n_out.pending = (n_fill != '0);
    end

    // Sequencer, state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_fill   <= '0;
            r_buttons <= '0;
            r_cur_x  <= '0;
            r_cur_y  <= 16'd199;
            r_mick_x <= '0;
            r_mick_y <= '0;
            r_press_cnt <= '{default: '0};
            r_rel_cnt   <= '{default: '0};
            r_press_pos <= '{default: '0};
            r_rel_pos   <= '{default: '0};
            r_text_mode <= 1'b1;
            r_double_y  <= 1'b0;
            r_scale_x   <= 16'd1;
            r_scale_y   <= 16'd1;
            r_event_mask <= '0;
            r_even_x    <= 1'b0;
            r_start_y   <= 16'd199;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    meq_pkg::REG_TEXT_MODE:  r_text_mode  <= i_cfg_data[0];
                    meq_pkg::REG_DOUBLE_Y:   r_double_y   <= i_cfg_data[0];
                    meq_pkg::REG_SCALE_X:    r_scale_x    <= i_cfg_data;
                    meq_pkg::REG_SCALE_Y:    r_scale_y    <= i_cfg_data;
                    meq_pkg::REG_EVENT_MASK: r_event_mask <= i_cfg_data[4:0];
                    meq_pkg::REG_EVEN_X:     r_even_x     <= i_cfg_data[0];
                    meq_pkg::REG_START_Y:    r_start_y    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // Load a new result or drop the one just taken.
            if (w_exec) begin
                r_ovalid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_item <= i_data;
                        r_cnt  <= '0;
                        r_state <= (i_data.cmd == meq_pkg::CMD_MOVE) ? ST_DIV : ST_EXEC;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(meq_pkg::DIV_W - 1)) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    // Hold here while the previous result still waits.
                    if (w_out_free) begin
                        r_state   <= ST_IDLE;
                        r_out     <= n_out;
                        r_fill    <= n_fill;
                        r_buttons <= n_buttons;
                        r_cur_x   <= n_cur_x;
                        r_cur_y   <= n_cur_y;
                        r_mick_x  <= n_mick_x;
                        r_mick_y  <= n_mick_y;
                        if (w_btn_ok && r_item.cmd == meq_pkg::CMD_PRESS) begin
                            r_press_cnt[r_item.button[0]] <=
                                r_press_cnt[r_item.button[0]] + 1'b1;
                            r_press_pos[r_item.button[0]] <= {r_cur_y, w_rep_x};
                        end
                        if (w_btn_ok && r_item.cmd == meq_pkg::CMD_RELEASE) begin
                            r_rel_cnt[r_item.button[0]] <= r_rel_cnt[r_item.button[0]] + 1'b1;
                            r_rel_pos[r_item.button[0]] <= {r_cur_y, w_rep_x};
                        end
                        if (r_item.cmd == meq_pkg::CMD_RDPRESS) begin
                            r_press_cnt[w_b] <= '0;
                        end
                        if (r_item.cmd == meq_pkg::CMD_RDRELEASE) begin
                            r_rel_cnt[w_b] <= '0;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // The fill count never exceeds the queue depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(QUEUE_DEPTH)) else $error("queue fill over depth");
    // A stalled result stays valid and unchanged.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_stall |=> r_ovalid && $stable(r_out))
        else $error("stalled result changed");
    // A result appears only after the execute cycle.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ST_EXEC) else $error("stray result");
    // A pop on a nonempty queue lowers the fill count by one.
    a_pop_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qctl.pop |=> r_fill == $past(r_fill) - 1'b1)
        else $error("pop fill mismatch");
endmodule
`default_nettype wire
